// ----- rtl/sara_pkg.sv -----
// shared types and constants for the shelf atlas rectangle allocator
// no dependencies; imported by every module of the block but the row ram
`default_nettype none

package sara_pkg;

  localparam int unsigned MAX_ROWS       = 64;
  localparam int unsigned MAX_ATLAS_SIZE = 16384;
  localparam int unsigned ROW_AW         = $clog2(MAX_ROWS);
  localparam int unsigned CNT_W          = $clog2(MAX_ROWS + 1);

  localparam int unsigned DIM_W = 15;
  localparam int unsigned POS_W = 14;
  localparam int unsigned LIM_W = DIM_W + 1;

  localparam logic [DIM_W-1:0] MAX_TEX_RESET = DIM_W'(4096);

  // h/10 by reciprocal multiply, exact for every 15 bit h
  localparam logic [15:0] RECIP_10    = 16'd52429;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned DIV10_W     = 12;
  localparam int unsigned PROD_W      = DIM_W + 16;

  localparam logic [DIM_W-1:0] FAIL_SIZE = DIM_W'(2);

  typedef logic [DIM_W-1:0] dim_t;
  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    dim_t glyph_width;
    dim_t glyph_height;
  } req_t;

  typedef struct packed {
    pos_t rect_left;
    pos_t rect_top;
    dim_t rect_width;
    dim_t rect_height;
    logic alloc_failed;
    dim_t atlas_width;
    dim_t atlas_height;
    logic atlas_grew;
  } rsp_t;

  typedef struct packed {
    dim_t top;
    dim_t height;
    dim_t fill;
  } row_t;

  localparam int unsigned ROW_W = $bits(row_t);

  typedef struct packed {
    logic              we;
    logic [ROW_AW-1:0] waddr;
    row_t              wdata;
    logic              re;
    logic [ROW_AW-1:0] raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_GROW,
    ST_UPD
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/sara_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module sara_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/sara_ctrl.sv -----
// request sequencer: row scan over the row ram, atlas growth, row update
// depends on sara_pkg; drives the row ram through a mem_req_t struct
`default_nettype none

module sara_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire sara_pkg::req_t    in_req,
  input  wire logic [sara_pkg::LIM_W-1:0] limit,
  output sara_pkg::mem_req_t     mem_req,
  input  wire sara_pkg::row_t    mem_rdata,
  output logic                   out_strobe,
  output sara_pkg::rsp_t         out_rsp
);
  import sara_pkg::*;

  state_t              state_r, state_nxt;
  req_t                req_r, req_nxt;
  logic [DIM_W+3:0]    h10_r, h10_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [DIM_W:0]      new_h_r, new_h_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [ROW_AW-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic                vld_r, vld_nxt;
  row_t                row_r, row_nxt;
  logic [ROW_AW-1:0]   sel_r, sel_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  dim_t                nrt_r, nrt_nxt;
  dim_t                aw_r, aw_nxt;
  dim_t                ah_r, ah_nxt;
  logic                grew_r, grew_nxt;
  rsp_t                out_r, out_nxt;
  logic                strobe_r, strobe_nxt;

  logic [DIM_W+2:0]    hr7;
  logic [DIM_W:0]      wfill;
  logic                fit;
  logic [DIM_W+1:0]    bottom;
  logic                need;
  logic                can_grow;
  rsp_t                fail_rsp;

  // row fit test on the word coming out of the ram
  always_comb begin
    hr7   = {mem_rdata.height, 3'b000} - {3'b000, mem_rdata.height};
    wfill = {1'b0, req_r.glyph_width} + {1'b0, mem_rdata.fill};
    fit   = (h10_r >= {1'b0, hr7}) && (req_r.glyph_height <= mem_rdata.height) &&
            (wfill <= {1'b0, aw_r});
  end

  always_comb begin
    bottom   = {2'b00, nrt_r} + {1'b0, new_h_r};
    need     = (bottom >= {2'b00, ah_r}) || (req_r.glyph_width >= aw_r);
    can_grow = ({aw_r, 1'b0} <= limit) && ({ah_r, 1'b0} <= limit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      nrt_r    <= '0;
      aw_r     <= DIM_W'(1);
      ah_r     <= DIM_W'(1);
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      nrt_r    <= nrt_nxt;
      aw_r     <= aw_nxt;
      ah_r     <= ah_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    h10_r     <= h10_nxt;
    prod_r    <= prod_nxt;
    new_h_r   <= new_h_nxt;
    idx_r     <= idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    vld_r     <= vld_nxt;
    row_r     <= row_nxt;
    sel_r     <= sel_nxt;
    grew_r    <= grew_nxt;
    out_r     <= out_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    h10_nxt     = h10_r;
    prod_nxt    = prod_r;
    new_h_nxt   = new_h_r;
    idx_nxt     = idx_r;
    cmp_idx_nxt = cmp_idx_r;
    vld_nxt     = vld_r;
    row_nxt     = row_r;
    sel_nxt     = sel_r;
    count_nxt   = count_r;
    nrt_nxt     = nrt_r;
    aw_nxt      = aw_r;
    ah_nxt      = ah_r;
    grew_nxt    = grew_r;
    out_nxt     = out_r;
    strobe_nxt  = 1'b0;
    mem_req     = '0;

    fail_rsp              = '0;
    fail_rsp.rect_width   = FAIL_SIZE;
    fail_rsp.rect_height  = FAIL_SIZE;
    fail_rsp.alloc_failed = 1'b1;
    fail_rsp.atlas_width  = aw_r;
    fail_rsp.atlas_height = ah_r;
    fail_rsp.atlas_grew   = grew_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        prod_nxt  = PROD_W'(req_r.glyph_height) * PROD_W'(RECIP_10);
        h10_nxt   = {1'b0, req_r.glyph_height, 3'b000} +
                    {3'b000, req_r.glyph_height, 1'b0};
        idx_nxt   = '0;
        vld_nxt   = 1'b0;
        grew_nxt  = 1'b0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        new_h_nxt = {1'b0, req_r.glyph_height} +
                    (DIM_W+1)'(prod_r[RECIP_SHIFT +: DIV10_W]);
        if (vld_r && fit) begin
          sel_nxt   = cmp_idx_r;
          row_nxt   = mem_rdata;
          state_nxt = ST_UPD;
        end else if (!vld_r && (idx_r >= count_r)) begin
          // pipeline drained with no hit
          if (count_r >= CNT_W'(MAX_ROWS)) begin
            out_nxt    = fail_rsp;
            strobe_nxt = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            state_nxt = ST_GROW;
          end
        end else begin
          // read the next row while the previous one is compared
          vld_nxt       = idx_r < count_r;
          mem_req.re    = vld_nxt;
          mem_req.raddr = idx_r[ROW_AW-1:0];
          cmp_idx_nxt   = idx_r[ROW_AW-1:0];
          if (vld_nxt) begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end
      end
      ST_GROW: begin
        if (need) begin
          if (can_grow) begin
            aw_nxt   = {aw_r[DIM_W-2:0], 1'b0};
            ah_nxt   = {ah_r[DIM_W-2:0], 1'b0};
            grew_nxt = 1'b1;
          end else begin
            out_nxt    = fail_rsp;
            strobe_nxt = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end else begin
          // open a new row below the others, already holding this rectangle
          mem_req.we            = 1'b1;
          mem_req.waddr         = count_r[ROW_AW-1:0];
          mem_req.wdata.top     = nrt_r;
          mem_req.wdata.height  = new_h_r[DIM_W-1:0];
          mem_req.wdata.fill    = req_r.glyph_width;
          count_nxt             = count_r + CNT_W'(1);
          nrt_nxt               = bottom[DIM_W-1:0];
          out_nxt.rect_left     = '0;
          out_nxt.rect_top      = nrt_r[POS_W-1:0];
          out_nxt.rect_width    = req_r.glyph_width;
          out_nxt.rect_height   = req_r.glyph_height;
          out_nxt.alloc_failed  = 1'b0;
          out_nxt.atlas_width   = aw_r;
          out_nxt.atlas_height  = ah_r;
          out_nxt.atlas_grew    = grew_r;
          strobe_nxt            = 1'b1;
          state_nxt             = ST_IDLE;
        end
      end
      ST_UPD: begin
        mem_req.we           = 1'b1;
        mem_req.waddr        = sel_r;
        mem_req.wdata.top    = row_r.top;
        mem_req.wdata.height = row_r.height;
        mem_req.wdata.fill   = row_r.fill + req_r.glyph_width;
        out_nxt.rect_left    = row_r.fill[POS_W-1:0];
        out_nxt.rect_top     = row_r.top[POS_W-1:0];
        out_nxt.rect_width   = req_r.glyph_width;
        out_nxt.rect_height  = req_r.glyph_height;
        out_nxt.alloc_failed = 1'b0;
        out_nxt.atlas_width  = aw_r;
        out_nxt.atlas_height = ah_r;
        out_nxt.atlas_grew   = grew_r;
        strobe_nxt           = 1'b1;
        state_nxt            = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy       = state_r != ST_IDLE;
  assign out_strobe = strobe_r;
  assign out_rsp    = out_r;

endmodule

`default_nettype wire

// ----- rtl/shelf_atlas_rect_allocator_core.sv -----
// top level of the shelf atlas rectangle allocator: limit register, row ram, sequencer
// depends on sara_pkg, sara_ram, sara_ctrl
//
//   channel | ports                        | transfer
//   --------+------------------------------+-------------------------------
//   request | start, busy, in_req          | edge with start high, busy low
//   result  | out_strobe, out_rsp          | every edge ending a strobe cycle
//   config  | cfg_we, cfg_wdata            | every edge with cfg_we high
//
// a request passes a prep step, then the row scan, which stops at the first row that fits
// and updates it; with no hit, atlas growth doubles the atlas while needed and opens a new
// row, or a failure rectangle comes back when the row table is full or the limit stops
// growth. the row scan makes one row ram read per cycle through the single read port.
// busy stays high until the result strobe. rows need no clearing after reset: only rows
// below the row count are read. results cannot be held off.
`default_nettype none

module shelf_atlas_rect_allocator_core (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire sara_pkg::req_t           in_req,
  output logic                          out_strobe,
  output sara_pkg::rsp_t                out_rsp,
  input  wire logic                     cfg_we,
  input  wire logic [sara_pkg::DIM_W-1:0] cfg_wdata
);
  import sara_pkg::*;

  dim_t             max_tex_r;
  logic [LIM_W-1:0] limit;
  mem_req_t         mem_req;
  row_t             mem_rdata;
  logic [ROW_W-1:0] rdata_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tex_r <= MAX_TEX_RESET;
    end else if (cfg_we) begin
      max_tex_r <= cfg_wdata;
    end
  end

  // effective size limit is the lesser of the device limit and the block maximum
  assign limit = ({1'b0, max_tex_r} < LIM_W'(MAX_ATLAS_SIZE)) ?
                 {1'b0, max_tex_r} : LIM_W'(MAX_ATLAS_SIZE);

  sara_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_ROWS)
  ) u_row_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rdata_raw)
  );

  assign mem_rdata = rdata_raw;

  sara_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .limit      (limit),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp)
  );

endmodule

`default_nettype wire

// ----- rtl/sara_checker.sv -----
// port level checks for shelf_atlas_rect_allocator_core, bound to the top level
// depends on sara_pkg
`default_nettype none

module sara_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           out_strobe,
  input wire sara_pkg::rsp_t out_rsp
);
  import sara_pkg::*;

  // a request transfer always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low after request transfer");

  // results are single cycle and come with the block idle again
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy && $past(busy))
    else $error("result strobe without preceding work");

  a_fail_rect: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_rsp.alloc_failed) |->
      (out_rsp.rect_left == '0) && (out_rsp.rect_top == '0) &&
      (out_rsp.rect_width == FAIL_SIZE) && (out_rsp.rect_height == FAIL_SIZE))
    else $error("failure rectangle malformed");

  // atlas grows in both dimensions together from one texel
  a_atlas_square: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_rsp.atlas_width == out_rsp.atlas_height) &&
                   $onehot(out_rsp.atlas_width))
    else $error("atlas size not a square power of two");

endmodule

bind shelf_atlas_rect_allocator_core sara_checker u_sara_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_rsp    (out_rsp)
);

`default_nettype wire

// ----- test/shelf_atlas_rect_allocator_core_tb.sv -----
`timescale 1ns / 100ps
// testbench for the shelf atlas rectangle allocator: directed and random glyph requests
// under several texture size limits, each result checked against a shelf packing model
// depends on sara_pkg and shelf_atlas_rect_allocator_core

import sara_pkg::*;

localparam int unsigned FAIL_DIM = 2;

class shelf_scoreboard;
  dim_t        row_top_tab[MAX_ROWS];
  dim_t        row_height_tab[MAX_ROWS];
  dim_t        row_fill_tab[MAX_ROWS];
  int unsigned rows_used;
  int unsigned next_top;
  int unsigned atlas_w;
  int unsigned atlas_h;
  dim_t        tex_limit;
  rsp_t        expected_rects[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned fails_seen;
  int unsigned growths_seen;

  function new();
    rows_used    = 0;
    next_top     = 0;
    atlas_w      = 1;
    atlas_h      = 1;
    tex_limit    = MAX_TEX_RESET;
    mismatches   = 0;
    results_seen = 0;
    fails_seen   = 0;
    growths_seen = 0;
  endfunction

  // packs one request into the shelves and queues the rectangle it should get
  function void note(req_t r);
    int unsigned w, h, lim, new_h, sel, i;
    bit          placed, failed, grew;
    rsp_t        e;
    w      = r.glyph_width;
    h      = r.glyph_height;
    lim    = (tex_limit < MAX_ATLAS_SIZE) ? tex_limit : MAX_ATLAS_SIZE;
    placed = 1'b0;
    failed = 1'b0;
    grew   = 1'b0;
    sel    = 0;
    // first row in creation order whose height ratio and free width suit
    for (i = 0; i < rows_used; i++) begin
      if (!placed && 10 * h >= 7 * row_height_tab[i] && h <= row_height_tab[i] &&
          w + row_fill_tab[i] <= atlas_w) begin
        sel    = i;
        placed = 1'b1;
      end
    end
    if (!placed) begin
      new_h = h + h / 10;
      if (rows_used >= MAX_ROWS) begin
        failed = 1'b1;
      end else begin
        while (!failed && (next_top + new_h >= atlas_h || w >= atlas_w)) begin
          if (atlas_w * 2 <= lim && atlas_h * 2 <= lim) begin
            atlas_w = atlas_w * 2;
            atlas_h = atlas_h * 2;
            grew    = 1'b1;
          end else begin
            failed = 1'b1;
          end
        end
        if (!failed) begin
          sel                 = rows_used;
          row_top_tab[sel]    = dim_t'(next_top);
          row_height_tab[sel] = dim_t'(new_h);
          row_fill_tab[sel]   = '0;
          rows_used++;
          next_top            = (next_top + new_h) & 32'h7fff;
          placed              = 1'b1;
        end
      end
    end
    e             = '0;
    e.rect_width  = dim_t'(FAIL_DIM);
    e.rect_height = dim_t'(FAIL_DIM);
    if (placed) begin
      e.rect_left       = pos_t'(row_fill_tab[sel]);
      e.rect_top        = pos_t'(row_top_tab[sel]);
      e.rect_width      = dim_t'(w);
      e.rect_height     = dim_t'(h);
      row_fill_tab[sel] = dim_t'(row_fill_tab[sel] + w);
    end
    e.alloc_failed = failed;
    e.atlas_width  = dim_t'(atlas_w);
    e.atlas_height = dim_t'(atlas_h);
    e.atlas_grew   = grew;
    if (failed) fails_seen++;
    if (grew) growths_seen++;
    expected_rects.insert(expected_rects.size(), e);
  endfunction

  function void cmp(string name, logic [DIM_W-1:0] e, logic [DIM_W-1:0] a);
    if (e !== a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      mismatches++;
    end
  endfunction

  function void check(rsp_t a);
    rsp_t e;
    if (expected_rects.size() == 0) begin
      $error("result strobe with no request outstanding");
      mismatches++;
      return;
    end
    e = expected_rects.pop_front();
    results_seen++;
    cmp("rect_left", e.rect_left, a.rect_left);
    cmp("rect_top", e.rect_top, a.rect_top);
    cmp("rect_width", e.rect_width, a.rect_width);
    cmp("rect_height", e.rect_height, a.rect_height);
    cmp("alloc_failed", e.alloc_failed, a.alloc_failed);
    cmp("atlas_width", e.atlas_width, a.atlas_width);
    cmp("atlas_height", e.atlas_height, a.atlas_height);
    cmp("atlas_grew", e.atlas_grew, a.atlas_grew);
  endfunction
endclass

module shelf_atlas_rect_allocator_core_tb;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  req_t             in_req = '0;
  logic             out_strobe;
  rsp_t             out_rsp;
  logic             cfg_we = 1'b0;
  logic [DIM_W-1:0] cfg_wdata = '0;

  shelf_scoreboard  sb;
  int unsigned      cycle_count = 0;
  int unsigned      requests_sent = 0;

  shelf_atlas_rect_allocator_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check(out_rsp);
  end

  function automatic req_t mk_req(input int unsigned w, input int unsigned h);
    req_t r;
    r.glyph_width  = dim_t'(w);
    r.glyph_height = dim_t'(h);
    return r;
  endfunction

  // sender idle share rotates every hundred requests sent, directed ones included
  function automatic int unsigned idle_for(input int unsigned n);
    case ((n / 100) % 3)
      0:       return 0;
      1:       return 76;
      default: return 14;
    endcase
  endfunction

  // flat requests are wide zero-height glyphs, each wider than half the atlas width when picked
  function automatic req_t pick_req(input int unsigned big_pct, input bit flat);
    int unsigned w, h, roll, aw;
    roll = $urandom_range(99);
    aw   = sb.atlas_w;
    if (flat && aw >= 4) begin
      w = $urandom_range(aw - 1, aw / 2 + 1);
      h = 0;
    end else if (roll < big_pct) begin
      w = $urandom_range(32767);
      h = $urandom_range(32767);
    end else if (roll < big_pct + 2) begin
      w = 0;
      h = $urandom_range(24);
    end else if (roll < big_pct + 4) begin
      w = $urandom_range(40);
      h = 0;
    end else if (roll < big_pct + 12) begin
      w = $urandom_range(120, 1);
      h = $urandom_range(300, 25);
    end else begin
      w = $urandom_range(40, 1);
      h = $urandom_range(24, 1);
    end
    return mk_req(w, h);
  endfunction

  task automatic send_req(input req_t r, input int unsigned idle_pct);
    int unsigned gap;
    gap = 0;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) gap++;
    if (idle_pct != 0 && $urandom_range(7) == 0) gap += $urandom_range(90);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note(r);
    requests_sent++;
  endtask

  // limit changes only once every result is back
  task automatic set_limit(input dim_t v);
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_rects.size() != 0 || busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we       <= 1'b0;
    sb.tex_limit = v;
  endtask

  task automatic run_random(input int unsigned count, input int unsigned big_pct,
                            input int unsigned flat_count);
    int unsigned k;
    for (k = 0; k < count; k++) begin
      send_req(pick_req(big_pct, k < flat_count), idle_for(requests_sent));
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero limit: nothing may grow, only zero sized rows fit the 1x1 atlas
    set_limit(dim_t'(0));
    send_req(mk_req(1, 1), 0);
    send_req(mk_req(0, 0), 0);
    send_req(mk_req(0, 0), 0);
    send_req(mk_req(0, 5), 0);
    send_req(mk_req(32767, 0), 0);
    send_req(mk_req(0, 32767), 0);
    send_req(mk_req(16384, 16384), 0);

    // limit of one still forbids a doubling
    set_limit(dim_t'(1));
    send_req(mk_req(1, 0), 0);
    send_req(mk_req(0, 0), 0);
    send_req(mk_req(1, 1), 0);

    // small page: growth, then growth that runs into the limit
    set_limit(dim_t'(16));
    send_req(mk_req(1, 1), 0);
    send_req(mk_req(16, 1), 0);
    send_req(mk_req(15, 1), 0);
    run_random(150, 0, 0);

    // ratio edges: row of height 20 takes 14..20, not 13 or 21
    set_limit(dim_t'(4096));
    send_req(mk_req(5, 19), 0);
    send_req(mk_req(5, 14), 0);
    send_req(mk_req(5, 13), 0);
    send_req(mk_req(5, 20), 0);
    send_req(mk_req(5, 21), 0);
    run_random(450, 0, 0);

    // all ones clamps to the block maximum; big glyphs push the page to it
    set_limit(dim_t'(32767));
    run_random(400, 5, 0);

    // limit below the current page, then fill the row table
    set_limit(dim_t'(100));
    run_random(200, 2, 70);

    start <= 1'b0;
    while (sb.expected_rects.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("%0d requests over six limit settings, %0d results checked",
             requests_sent, sb.results_seen);
    $display("%0d failure rectangles, %0d requests grew the page, %0d of %0d rows opened",
             sb.fails_seen, sb.growths_seen, sb.rows_used, MAX_ROWS);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
